>>> hdl/skps_pkg.sv
// Shared constants and types for the stable key/payload sort unit.
package skps_pkg;

  localparam int unsigned MaxItemsDef    = 32;
  localparam int unsigned KeyBitsDef     = 32;
  localparam int unsigned PayloadBitsDef = 32;

  // Per-cycle command that the controller broadcasts to every cell.
  typedef struct packed {
    logic insert;  // a new word is inserted into its sorted place
    logic shift;   // every cell takes the contents of its upper neighbor
  } cell_ctrl_t;

endpackage

>>> hdl/skps_cell.sv
// One storage cell of the insertion chain: holds a key, its payload and a valid bit.
module skps_cell #(
  parameter int unsigned KEY_BITS     = skps_pkg::KeyBitsDef,
  parameter int unsigned PAYLOAD_BITS = skps_pkg::PayloadBitsDef,
  parameter bit          DESCEND      = 1'b0
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  skps_pkg::cell_ctrl_t           ctrl_i,
  input  logic signed [KEY_BITS-1:0]     new_key_i,
  input  logic        [PAYLOAD_BITS-1:0] new_payload_i,
  input  logic signed [KEY_BITS-1:0]     prev_key_i,
  input  logic        [PAYLOAD_BITS-1:0] prev_payload_i,
  input  logic                           prev_valid_i,
  input  logic                           prev_after_i,
  input  logic signed [KEY_BITS-1:0]     next_key_i,
  input  logic        [PAYLOAD_BITS-1:0] next_payload_i,
  input  logic                           next_valid_i,
  output logic signed [KEY_BITS-1:0]     key_o,
  output logic        [PAYLOAD_BITS-1:0] payload_o,
  output logic                           valid_o,
  output logic                           after_o
);

  logic signed [KEY_BITS-1:0]     key_q, key_d;
  logic        [PAYLOAD_BITS-1:0] payload_q, payload_d;
  logic                           valid_q, valid_d;
  logic                           key_after;

  // Strict compare only, so an equal new key lands behind the stored one.
  assign key_after = DESCEND ? (key_q < new_key_i) : (key_q > new_key_i);
  // An empty cell sorts after everything.
  assign after_o   = !valid_q || key_after;

  always_comb begin
    key_d     = key_q;
    payload_d = payload_q;
    valid_d   = valid_q;
    if (ctrl_i.shift) begin
      key_d     = next_key_i;
      payload_d = next_payload_i;
      valid_d   = next_valid_i;
    end else if (ctrl_i.insert && after_o) begin
      if (prev_after_i) begin
        key_d     = prev_key_i;
        payload_d = prev_payload_i;
      end else begin
        key_d     = new_key_i;
        payload_d = new_payload_i;
      end
      valid_d = valid_q | prev_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    payload_q <= payload_d;
  end

  assign key_o     = key_q;
  assign payload_o = payload_q;
  assign valid_o   = valid_q;

endmodule

>>> hdl/skps_chain.sv
// Row of insertion cells kept sorted in one fixed direction.
module skps_chain #(
  parameter int unsigned MAX_ITEMS    = skps_pkg::MaxItemsDef,
  parameter int unsigned KEY_BITS     = skps_pkg::KeyBitsDef,
  parameter int unsigned PAYLOAD_BITS = skps_pkg::PayloadBitsDef,
  parameter bit          DESCEND      = 1'b0
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  skps_pkg::cell_ctrl_t           ctrl_i,
  input  logic signed [KEY_BITS-1:0]     new_key_i,
  input  logic        [PAYLOAD_BITS-1:0] new_payload_i,
  output logic signed [KEY_BITS-1:0]     head_key_o,
  output logic        [PAYLOAD_BITS-1:0] head_payload_o,
  output logic                           head_valid_o,
  output logic                           second_valid_o,
  output logic                           full_o
);

  logic signed [KEY_BITS-1:0]     key_w     [MAX_ITEMS];
  logic        [PAYLOAD_BITS-1:0] payload_w [MAX_ITEMS];
  logic                           valid_w   [MAX_ITEMS];
  logic                           after_w   [MAX_ITEMS];

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic signed [KEY_BITS-1:0]     prev_key, next_key;
    logic        [PAYLOAD_BITS-1:0] prev_payload, next_payload;
    logic                           prev_valid, prev_after, next_valid;

    if (i == 0) begin : g_first
      assign prev_key     = new_key_i;
      assign prev_payload = new_payload_i;
      assign prev_valid   = 1'b1;
      assign prev_after   = 1'b0;
    end else begin : g_inner
      assign prev_key     = key_w[i-1];
      assign prev_payload = payload_w[i-1];
      assign prev_valid   = valid_w[i-1];
      assign prev_after   = after_w[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_last
      assign next_key     = '0;
      assign next_payload = '0;
      assign next_valid   = 1'b0;
    end else begin : g_body
      assign next_key     = key_w[i+1];
      assign next_payload = payload_w[i+1];
      assign next_valid   = valid_w[i+1];
    end

    skps_cell #(
      .KEY_BITS    (KEY_BITS),
      .PAYLOAD_BITS(PAYLOAD_BITS),
      .DESCEND     (DESCEND)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl_i),
      .new_key_i     (new_key_i),
      .new_payload_i (new_payload_i),
      .prev_key_i    (prev_key),
      .prev_payload_i(prev_payload),
      .prev_valid_i  (prev_valid),
      .prev_after_i  (prev_after),
      .next_key_i    (next_key),
      .next_payload_i(next_payload),
      .next_valid_i  (next_valid),
      .key_o         (key_w[i]),
      .payload_o     (payload_w[i]),
      .valid_o       (valid_w[i]),
      .after_o       (after_w[i])
    );
  end

  assign head_key_o     = key_w[0];
  assign head_payload_o = payload_w[0];
  assign head_valid_o   = valid_w[0];
  assign second_valid_o = valid_w[1];
  assign full_o         = valid_w[MAX_ITEMS-1];

endmodule

>>> hdl/stable_key_payload_sort_unit.sv
// Top level of the stable key/payload sort unit.
// The unit collects a batch of signed keys with payloads, one word per cycle, and inserts
// each word into its sorted place in two rows of MAX_ITEMS cells, one kept ascending and one
// descending, both stable. The word flagged batch_end closes the batch; from the next cycle
// the row chosen by the descending bit at that moment drains one word per cycle from its
// head while out_ready_i is high, and in_ready_o stays low until its last word is taken.
// The cycle time is set by the broadcast compare in each cell. Words arriving while MAX_ITEMS
// are held are dropped and overflowed_o is set on the whole batch.
module stable_key_payload_sort_unit #(
  parameter int unsigned MAX_ITEMS    = skps_pkg::MaxItemsDef,
  parameter int unsigned KEY_BITS     = skps_pkg::KeyBitsDef,
  parameter int unsigned PAYLOAD_BITS = skps_pkg::PayloadBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [KEY_BITS-1:0]     sort_key_i,
  input  logic        [PAYLOAD_BITS-1:0] payload_i,
  input  logic                           batch_end_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [KEY_BITS-1:0]     sorted_key_o,
  output logic        [PAYLOAD_BITS-1:0] sorted_payload_o,
  output logic                           final_item_o,
  output logic                           overflowed_o
);

  logic descending_q;
  logic drain_q, drain_d;
  logic dir_q, dir_d;
  logic drop_q, drop_d;
  logic ovf_q, ovf_d;

  skps_pkg::cell_ctrl_t ctrl;

  logic signed [KEY_BITS-1:0]     asc_key, dsc_key;
  logic        [PAYLOAD_BITS-1:0] asc_payload, dsc_payload;
  logic                           asc_head_valid, dsc_head_valid;
  logic                           asc_second_valid, dsc_second_valid;
  logic                           asc_full, dsc_full;
  logic                           in_acc, out_acc, last_word;

  assign in_ready_o = !drain_q;
  assign in_acc     = in_valid_i && in_ready_o;

  // Both rows hold the same number of words, so either one gives the fill state.
  assign out_valid_o = drain_q && asc_head_valid;
  assign out_acc     = out_valid_o && out_ready_i;
  assign last_word   = !asc_second_valid;

  assign ctrl.insert = in_acc && !asc_full;
  assign ctrl.shift  = out_acc;

  always_comb begin
    drain_d = drain_q;
    dir_d   = dir_q;
    drop_d  = drop_q;
    ovf_d   = ovf_q;
    if (in_acc) begin
      if (batch_end_i) begin
        drain_d = 1'b1;
        dir_d   = descending_q;
        ovf_d   = drop_q | asc_full;
        drop_d  = 1'b0;
      end else if (asc_full) begin
        drop_d = 1'b1;
      end
    end
    if (out_acc && last_word) begin
      drain_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      descending_q <= 1'b0;
      drain_q      <= 1'b0;
      dir_q        <= 1'b0;
      drop_q       <= 1'b0;
      ovf_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        descending_q <= cfg_wdata_i;
      end
      drain_q <= drain_d;
      dir_q   <= dir_d;
      drop_q  <= drop_d;
      ovf_q   <= ovf_d;
    end
  end

  skps_chain #(
    .MAX_ITEMS   (MAX_ITEMS),
    .KEY_BITS    (KEY_BITS),
    .PAYLOAD_BITS(PAYLOAD_BITS),
    .DESCEND     (1'b0)
  ) u_asc_chain (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .new_key_i     (sort_key_i),
    .new_payload_i (payload_i),
    .head_key_o    (asc_key),
    .head_payload_o(asc_payload),
    .head_valid_o  (asc_head_valid),
    .second_valid_o(asc_second_valid),
    .full_o        (asc_full)
  );

  skps_chain #(
    .MAX_ITEMS   (MAX_ITEMS),
    .KEY_BITS    (KEY_BITS),
    .PAYLOAD_BITS(PAYLOAD_BITS),
    .DESCEND     (1'b1)
  ) u_dsc_chain (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .new_key_i     (sort_key_i),
    .new_payload_i (payload_i),
    .head_key_o    (dsc_key),
    .head_payload_o(dsc_payload),
    .head_valid_o  (dsc_head_valid),
    .second_valid_o(dsc_second_valid),
    .full_o        (dsc_full)
  );

  // The descending row mirrors the ascending one in fill state; its flags only
  // take part when it is the row being drained.
  assign sorted_key_o     = dir_q ? dsc_key : asc_key;
  assign sorted_payload_o = dir_q ? dsc_payload : asc_payload;
  assign final_item_o     = dir_q ? (!dsc_second_valid && dsc_head_valid && !dsc_full)
                                  : last_word;
  assign overflowed_o     = ovf_q;

endmodule
